### src/cser_pkg.sv
// ----------------------------------------------------------------------------
// cser_pkg
// shared types, codes and reset values of the segmented entry reassembler
// ----------------------------------------------------------------------------
package cser_pkg;

	localparam int STORE_BYTES_DEF = 256;

	localparam logic [3:0] REQUEST_CODE  = 4'd1;
	localparam logic [3:0] EXTENDED_FLAG = 4'd8;
	localparam logic [3:0] SEGMENT_CODE  = REQUEST_CODE | EXTENDED_FLAG;
	localparam logic [3:0] SYNC_CODE     = 4'd2;
	localparam logic [7:0] TRIGGER_CODE  = 8'd1;

	localparam logic [15:0] HEARTBEAT_RESET = 16'd200;
	localparam logic [15:0] SYNC_RESET      = 16'd10;

	localparam logic       KIND_DATA    = 1'b0;
	localparam logic       KIND_TRIGGER = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_DRD,
		S_DUPD,
		S_EMIT,
		S_SYNC
	} state_t;

	// one read-modify-write of a store word
	typedef struct packed {
		logic        is_header;
		logic [5:0]  word;
		logic [7:0]  offset;
		logic [2:0]  count;
		logic [7:0]  length;
		logic [63:0] data;
	} merge_req_t;

endpackage

### src/cser_ram.sv
// ----------------------------------------------------------------------------
// cser_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cser_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### src/cser_merge.sv
// ----------------------------------------------------------------------------
// cser_merge
// byte-lane merge of frame bytes into one store word read back from the ram
// ----------------------------------------------------------------------------
module cser_merge #(
	parameter int STORE_BYTES = cser_pkg::STORE_BYTES_DEF
) (
	input  cser_pkg::merge_req_t req,
	input  logic [63:0]          rd_data,
	output logic [63:0]          wr_data,
	output logic                 wr_en
);

	import cser_pkg::*;

	logic [8:0] lane_addr;
	logic [8:0] rel;
	logic [2:0] rel_sel;
	logic       lane_en;
	logic [7:0] lane_byte;

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		lane_addr = '0;
		rel       = '0;
		rel_sel   = '0;
		lane_en   = 1'b0;
		lane_byte = '0;
		for (int b = 0; b < 8; b++) begin
			lane_addr = {req.word, 3'(b)};
			rel       = lane_addr - {1'b0, req.offset};
			rel_sel   = rel[2:0] + 3'd1;
			if (req.is_header) begin
				// header bytes d4..d7 land on store bytes 0..3
				lane_en   = (req.word == 6'd0) && (b < 4) &&
					((req.length > 8'd4) || (8'(b) < req.length));
				lane_byte = req.data[8*((b+4)&7) +: 8];
			end else begin
				lane_en   = (lane_addr >= {1'b0, req.offset}) &&
					(rel < 9'(req.count)) && (lane_addr < {1'b0, req.length});
				lane_byte = req.data[{rel_sel, 3'b000} +: 8];
			end
			lane_en = lane_en && (lane_addr < 9'(STORE_BYTES));
			if (lane_en) begin
				wr_data[8*b +: 8] = lane_byte;
				wr_en = 1'b1;
			end
		end
	end

endmodule

### src/can_segmented_entry_reassembler_core.sv
// ----------------------------------------------------------------------------
// can_segmented_entry_reassembler_core
// rebuilds object-dictionary entries from extended can header and segment frames
// ----------------------------------------------------------------------------
// input channel: one received frame per request (frame_id, frame_length,
// frame_data). output channel: result words, a run per delivered entry with
// last on its final word, or a single sync trigger event.
// entry bytes live in a ram of 64-bit words; every frame that writes the
// store does a read-modify-write of one word (header) or two words
// (segment), each through the single ram read port.
// a frame that writes nothing leaves the sequencer in S_IDLE; a sync trigger
// is shown in the cycle after its frame is taken, and the next frame waits
// until it is accepted; a header passes S_RD and S_WR, a segment S_RD, S_WR,
// S_RD and S_WR, before the next frame is taken.
// on delivery word 0 is read (S_DRD) for the interval update (S_DUPD), then
// the words stream out at one per cycle while the receiver is ready; a full
// 255-byte entry is 32 words.
// frames are not taken while a run is being delivered.
// reset: segment map all ones, held entry zero, heartbeat 200, sync 10;
// the store contents are unknown until written.
// receiver stall: the shown word holds and the ram keeps re-reading it.
// ----------------------------------------------------------------------------
module can_segmented_entry_reassembler_core #(
	parameter int STORE_BYTES = cser_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [28:0] frame_id,
	input  logic [3:0]  frame_length,
	input  logic [63:0] frame_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [11:0] source_id,
	output logic [15:0] entry_index,
	output logic [7:0]  entry_subindex,
	output logic [7:0]  entry_length,
	output logic [4:0]  word_number,
	output logic [63:0] value_word,
	output logic        last,
	output logic [15:0] heartbeat_now,
	output logic [15:0] sync_now
);

	import cser_pkg::*;

	localparam int WORDS = (STORE_BYTES + 7) / 8;
	localparam int AW    = $clog2(WORDS);

	state_t state_q, state_d;

	logic [63:0] segment_map_q;
	logic [15:0] held_index_q;
	logic [7:0]  held_subindex_q;
	logic [7:0]  held_length_q;
	logic [15:0] heartbeat_q;
	logic [15:0] sync_q;

	logic [63:0] data_q;
	logic [11:0] src_q;
	logic [7:0]  offset_q;
	logic [2:0]  count_q;
	logic        is_header_q;
	logic        two_q;
	logic        second_q;
	logic        deliver_q;
	logic [5:0]  wr_word_q;

	logic        res_kind_q;
	logic [11:0] res_src_q;
	logic [15:0] res_index_q;
	logic [7:0]  res_sub_q;
	logic [7:0]  res_len_q;
	logic [4:0]  last_k_q;
	logic [4:0]  k_q;

	logic in_fire, out_fire, is_last;

	// frame decode
	logic [3:0]  cmd;
	logic        is_hdr, is_seg, is_sync;
	logic        hdr_go, seg_go, seg_write, sync_go;
	logic [5:0]  seg_s;
	logic [8:0]  seg_off;
	logic [63:0] seg_map;
	logic [63:0] hdr_map;
	logic [7:0]  hdr_len;
	logic [2:0]  frame_count;

	// memory side
	logic [AW-1:0]  rd_addr;
	logic [63:0]    rd_data;
	logic [63:0]    mg_data;
	logic           mg_en;
	logic           ram_we;
	merge_req_t     mreq;
	logic [4:0]     k_next;
	logic [7:0]     len_m1;
	logic [63:0]    masked_word;
	logic [8:0]     rd_byte_addr;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign is_last  = res_kind_q || (k_q == last_k_q);

	assign cmd     = frame_id[27:24];
	assign is_hdr  = (cmd == REQUEST_CODE);
	assign is_seg  = !is_hdr && (cmd == SEGMENT_CODE);
	assign is_sync = !is_hdr && !is_seg && (cmd == SYNC_CODE);

	assign hdr_len   = frame_data[31:24];
	assign hdr_go    = is_hdr && (frame_length >= 4'd4);
	assign seg_s     = frame_data[5:0];
	assign seg_go    = is_seg && (frame_data[7:6] == 2'b00);
	// 4 + 7*s without a multiplier
	assign seg_off   = {seg_s, 3'b000} - {3'b000, seg_s} + 9'd4;
	assign seg_write = seg_go && (seg_off < {1'b0, held_length_q});
	assign seg_map   = segment_map_q | (64'd1 << seg_s);
	assign sync_go   = is_sync && (frame_data[31:24] == TRIGGER_CODE);

	// segment s is awaited when 4 + 7*s lies below the length
	always_comb begin
		for (int s = 0; s < 64; s++) begin
			hdr_map[s] = !(9'(7*s + 4) < {1'b0, hdr_len});
		end
	end

	always_comb begin
		if (frame_length == 4'd0) begin
			frame_count = 3'd0;
		end else if (frame_length >= 4'd8) begin
			frame_count = 3'd7;
		end else begin
			frame_count = 3'(frame_length - 4'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					priority if (hdr_go) begin
						state_d = S_RD;
					end else if (seg_write) begin
						state_d = S_RD;
					end else if (sync_go) begin
						state_d = S_SYNC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_RD: state_d = S_WR;
			S_WR: begin
				if (two_q && !second_q) begin
					state_d = S_RD;
				end else if (deliver_q) begin
					state_d = S_DRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DRD:  state_d = S_DUPD;
			S_DUPD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_fire && is_last) begin
					state_d = S_IDLE;
				end
			end
			S_SYNC: begin
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign k_next = k_q + 5'd1;

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		rd_addr   = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_RD:   rd_addr  = wr_word_q[AW-1:0];
			S_WR:   ram_we   = mg_en;
			S_DRD:  rd_addr  = '0;
			S_DUPD: rd_addr  = '0;
			S_EMIT: begin
				out_valid = 1'b1;
				// stay on the shown word while stalled
				rd_addr   = (out_fire && !is_last) ? k_next[AW-1:0] : k_q[AW-1:0];
			end
			S_SYNC: out_valid = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	assign mreq = '{
		is_header: is_header_q,
		word:      wr_word_q,
		offset:    offset_q,
		count:     count_q,
		length:    held_length_q,
		data:      data_q
	};

	cser_merge #(
		.STORE_BYTES(STORE_BYTES)
	) u_merge (
		.req     (mreq),
		.rd_data (rd_data),
		.wr_data (mg_data),
		.wr_en   (mg_en)
	);

	cser_ram #(
		.WIDTH(64),
		.DEPTH(WORDS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_word_q[AW-1:0]),
		.wr_data (mg_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			segment_map_q   <= '1;
			held_index_q    <= '0;
			held_subindex_q <= '0;
			held_length_q   <= '0;
			heartbeat_q     <= HEARTBEAT_RESET;
			sync_q          <= SYNC_RESET;
			is_header_q     <= 1'b0;
			two_q           <= 1'b0;
			second_q        <= 1'b0;
			deliver_q       <= 1'b0;
			res_kind_q      <= KIND_DATA;
			k_q             <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						priority if (hdr_go) begin
							held_index_q    <= frame_data[15:0];
							held_subindex_q <= frame_data[23:16];
							held_length_q   <= hdr_len;
							segment_map_q   <= (hdr_len <= 8'd4) ? '1 : hdr_map;
							is_header_q     <= 1'b1;
							two_q           <= 1'b0;
							second_q        <= 1'b0;
							deliver_q       <= (hdr_len <= 8'd4);
						end else if (seg_go) begin
							segment_map_q <= seg_map;
							is_header_q   <= 1'b0;
							two_q         <= 1'b1;
							second_q      <= 1'b0;
							deliver_q     <= (seg_map == '1);
						end else if (sync_go) begin
							res_kind_q <= KIND_TRIGGER;
							k_q        <= '0;
						end else begin
							deliver_q <= 1'b0;
						end
					end
				end
				S_WR: begin
					if (two_q && !second_q) begin
						second_q <= 1'b1;
					end
				end
				S_DUPD: begin
					if (held_index_q == 16'd0) begin
						if (held_subindex_q == 8'd0) begin
							heartbeat_q <= rd_data[15:0];
						end else if (held_subindex_q == 8'd1) begin
							sync_q <= rd_data[15:0];
						end
					end
					res_kind_q <= KIND_DATA;
					k_q        <= '0;
				end
				S_EMIT: begin
					if (out_fire && !is_last) begin
						k_q <= k_next;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	assign len_m1 = held_length_q - 8'd1;

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire) begin
			data_q   <= frame_data;
			src_q    <= frame_id[23:12];
			offset_q <= seg_off[7:0];
			count_q  <= frame_count;
			if (hdr_go) begin
				wr_word_q <= '0;
			end else begin
				wr_word_q <= {1'b0, seg_off[7:3]};
			end
			if (sync_go) begin
				res_src_q   <= frame_id[23:12];
				res_index_q <= frame_data[15:0];
				res_sub_q   <= frame_data[23:16];
				res_len_q   <= '0;
				last_k_q    <= '0;
			end
		end
		if (state_q == S_WR && two_q && !second_q) begin
			wr_word_q <= wr_word_q + 6'd1;
		end
		if (state_q == S_DUPD) begin
			res_src_q   <= src_q;
			res_index_q <= held_index_q;
			res_sub_q   <= held_subindex_q;
			res_len_q   <= held_length_q;
			last_k_q    <= (held_length_q == 8'd0) ? 5'd0 : len_m1[7:3];
		end
	end

	// bytes at or beyond the length, or outside the store, show as zero
	always_comb begin
		masked_word  = '0;
		rd_byte_addr = '0;
		for (int b = 0; b < 8; b++) begin
			rd_byte_addr = {1'b0, k_q, 3'(b)};
			if ((rd_byte_addr < {1'b0, res_len_q}) && (rd_byte_addr < 9'(STORE_BYTES))) begin
				masked_word[8*b +: 8] = rd_data[8*b +: 8];
			end
		end
	end

	assign kind           = res_kind_q;
	assign source_id      = res_src_q;
	assign entry_index    = res_index_q;
	assign entry_subindex = res_sub_q;
	assign entry_length   = res_len_q;
	assign word_number    = res_kind_q ? 5'd0 : k_q;
	assign value_word     = res_kind_q ? 64'd0 : masked_word;
	assign last           = is_last;
	assign heartbeat_now  = heartbeat_q;
	assign sync_now       = sync_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is shown");

	a_word_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_DATA)) |-> (word_number <= last_k_q))
		else $error("word number past the end of the entry");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("not ready after the final word of a run");

	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!out_valid && !in_ready))
		else $error("store written outside a merge cycle");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the segmented entry reassembler core
// ----------------------------------------------------------------------------
// a short table of directed frames (resets, extremes, ignored frames, interval
// updates, re-delivery) is followed by random header and segment sequences
// with noise mixed in, under four idling mixes. every result is compared
// field by field with a table entry or a local model of the reassembly.
// ----------------------------------------------------------------------------
module tb;
	import cser_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [11:0] src;
		logic [15:0] idx;
		logic [7:0]  sub;
		logic [7:0]  len;
		logic [4:0]  wnum;
		logic [63:0] word;
		logic        last;
		logic [15:0] hb;
		logic [15:0] sync;
	} out_word_t;

	typedef struct {
		logic [28:0] id;
		logic [3:0]  flen;
		logic [63:0] data;
		bit          typed;
		out_word_t   want;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [28:0] frame_id = '0;
	logic [3:0]  frame_length = '0;
	logic [63:0] frame_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [11:0] source_id;
	logic [15:0] entry_index;
	logic [7:0]  entry_subindex;
	logic [7:0]  entry_length;
	logic [4:0]  word_number;
	logic [63:0] value_word;
	logic        last;
	logic [15:0] heartbeat_now;
	logic [15:0] sync_now;

	can_segmented_entry_reassembler_core dut (.*);

	// model state
	logic [7:0]  entry_bytes [STORE_BYTES_DEF];
	logic [63:0] seg_map = {64{1'b1}};
	logic [15:0] cur_index = '0;
	logic [7:0]  cur_sub = '0;
	logic [7:0]  cur_len = '0;
	logic [15:0] hb_ival = HEARTBEAT_RESET;
	logic [15:0] sync_ival = SYNC_RESET;

	out_word_t  words_due [$];
	frame_row_t dir_rows [$];
	int         fail_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	always #1 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [28:0] mk_id(input logic top, input logic [3:0] cmd,
			input logic [11:0] src, input logic [11:0] low);
		return {top, cmd, src, low};
	endfunction

	function automatic logic [28:0] rand_id(input logic [3:0] cmd);
		return mk_id(1'($urandom), cmd, 12'($urandom), 12'($urandom));
	endfunction

	task automatic deliver_entry(input logic [11:0] src, ref out_word_t q[$]);
		int        words;
		out_word_t w;
		// interval update comes before the words go out
		if (cur_index == 16'd0) begin
			if (cur_sub == 8'd0)
				hb_ival = {entry_bytes[1], entry_bytes[0]};
			else if (cur_sub == 8'd1)
				sync_ival = {entry_bytes[1], entry_bytes[0]};
		end
		words = (int'(cur_len) + 7) / 8;
		if (words == 0)
			words = 1;
		for (int k = 0; k < words; k++) begin
			w = '0;
			w.kind = KIND_DATA;
			w.src = src;
			w.idx = cur_index;
			w.sub = cur_sub;
			w.len = cur_len;
			w.wnum = 5'(k);
			for (int i = 0; i < 8; i++)
				if (k * 8 + i < int'(cur_len))
					w.word[i*8 +: 8] = entry_bytes[k*8 + i];
			w.last = (k == words - 1);
			w.hb = hb_ival;
			w.sync = sync_ival;
			q.push_back(w);
		end
	endtask

	task automatic reassemble_frame(input logic [28:0] id, input logic [3:0] flen,
			input logic [63:0] data, ref out_word_t q[$]);
		logic [3:0]  cmd;
		logic [11:0] src;
		int          segs;
		int          off;
		int          n;
		int          s;
		cmd = id[27:24];
		src = id[23:12];
		if (cmd == REQUEST_CODE) begin
			if (flen >= 4'd4) begin
				cur_index = data[15:0];
				cur_sub = data[23:16];
				cur_len = data[31:24];
				if (cur_len <= 8'd4) begin
					for (int i = 0; i < int'(cur_len); i++)
						entry_bytes[i] = data[(4+i)*8 +: 8];
					seg_map = {64{1'b1}};
					deliver_entry(src, q);
				end else begin
					segs = (int'(cur_len) + 2) / 7;
					seg_map = {64{1'b1}} << segs;
					for (int i = 0; i < 4; i++)
						entry_bytes[i] = data[(4+i)*8 +: 8];
				end
			end
		end else if (cmd == SEGMENT_CODE) begin
			s = int'(data[7:0]);
			if (s < 64) begin
				seg_map[s] = 1'b1;
				off = 4 + 7 * s;
				if (off < int'(cur_len)) begin
					n = (flen > 4'd8) ? 8 : int'(flen);
					// bytes past the entry length are dropped
					for (int i = 1; i < n; i++)
						if (off + i - 1 < int'(cur_len))
							entry_bytes[off + i - 1] = data[i*8 +: 8];
					if (seg_map == {64{1'b1}})
						deliver_entry(src, q);
				end
			end
		end else if (cmd == SYNC_CODE) begin
			if (data[31:24] == TRIGGER_CODE)
				q.push_back('{KIND_TRIGGER, src, data[15:0], data[23:16], 8'd0, 5'd0,
					64'd0, 1'b1, hb_ival, sync_ival});
		end
	endtask

	// caller stands at a rising edge; returns at the edge that takes the request
	task automatic send_frame(input logic [28:0] id, input logic [3:0] flen,
			input logic [63:0] data, input bit typed, input out_word_t want);
		out_word_t got [$];
		int        gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		reassemble_frame(id, flen, data, got);
		if (typed)
			words_due.push_back(want);
		else
			foreach (got[i])
				words_due.push_back(got[i]);
		in_valid <= 1'b1;
		frame_id <= id;
		frame_length <= flen;
		frame_data <= data;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_segment(input int s, input logic [3:0] flen);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[7:0] = 8'(s);
		send_frame(rand_id(SEGMENT_CODE), flen, d, 1'b0, '0);
	endtask

	// frames that do not belong to the entry under way
	task automatic send_noise(inout int sent);
		logic [63:0] d;
		logic [3:0]  c;
		d = {$urandom, $urandom};
		case ($urandom_range(4))
			0: begin
				if ($urandom_range(1))
					d[31:24] = TRIGGER_CODE;
				send_frame(rand_id(SYNC_CODE), 4'($urandom), d, 1'b0, '0);
				sent++;
			end
			1: begin
				do c = 4'($urandom); while (c == REQUEST_CODE || c == SEGMENT_CODE ||
					c == SYNC_CODE);
				send_frame(rand_id(c), 4'($urandom), d, 1'b0, '0);
				sent++;
			end
			2: begin
				d[7:0] = 8'($urandom_range(255, 64));
				send_frame(rand_id(SEGMENT_CODE), 4'($urandom), d, 1'b0, '0);
				sent++;
			end
			3: begin
				send_frame(rand_id(REQUEST_CODE), 4'($urandom_range(3)), d, 1'b0, '0);
				sent++;
			end
			default: begin
				// stray segment, may complete or re-deliver the held entry
				d[7:0] = 8'($urandom_range(63));
				send_frame(rand_id(SEGMENT_CODE), 4'($urandom), d, 1'b0, '0);
				sent++;
			end
		endcase
	endtask

	// header then its segments in shuffled order; clean means nothing missing
	task automatic send_entry(input int len, input bit clean, inout int sent);
		logic [63:0] d;
		logic [15:0] idx;
		logic [3:0]  hflen;
		int          segs;
		int          j;
		int          t;
		int          skip;
		int          order [$];
		idx = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
		d = {$urandom, $urandom};
		d[15:0] = idx;
		d[23:16] = (idx == 16'd0) ? 8'($urandom_range(2)) : 8'($urandom);
		d[31:24] = 8'(len);
		hflen = (!clean && $urandom_range(3) == 0) ? 4'($urandom_range(15, 4)) : 4'd8;
		send_frame(rand_id(REQUEST_CODE), hflen, d, 1'b0, '0);
		sent++;
		if (len > 4) begin
			segs = (len + 2) / 7;
			for (int i = 0; i < segs; i++)
				order.push_back(i);
			for (int i = segs - 1; i > 0; i--) begin
				j = $urandom_range(i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			skip = (!clean && $urandom_range(19) == 0) ? $urandom_range(segs - 1) : -1;
			foreach (order[i]) begin
				if (i != skip) begin
					if (!clean && $urandom_range(9) == 0)
						send_noise(sent);
					send_segment(order[i], (!clean && $urandom_range(9) == 0) ?
						4'($urandom) : 4'd8);
					sent++;
					if (!clean && $urandom_range(14) == 0) begin
						send_segment(order[i], 4'd8);
						sent++;
					end
				end
			end
			if (!clean && $urandom_range(9) == 0) begin
				send_segment($urandom_range(segs - 1), 4'd8);
				sent++;
			end
		end
	endtask

	task automatic run_random(input int quota);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(9) < 8) begin
				r = $urandom_range(99);
				if (r < 10)
					len = $urandom_range(4);
				else if (r < 80)
					len = $urandom_range(40, 5);
				else if (r < 96)
					len = $urandom_range(254, 41);
				else
					len = 255;
				send_entry(len, 1'b0, sent);
			end else begin
				send_noise(sent);
			end
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		out_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (words_due.size() == 0) begin
				$error("unexpected result: kind %0d index %h word %h", kind, entry_index,
					value_word);
				fail_count++;
			end else begin
				w = words_due.pop_front();
				check_field("kind", 64'(w.kind), 64'(kind));
				check_field("source_id", 64'(w.src), 64'(source_id));
				check_field("entry_index", 64'(w.idx), 64'(entry_index));
				check_field("entry_subindex", 64'(w.sub), 64'(entry_subindex));
				check_field("entry_length", 64'(w.len), 64'(entry_length));
				check_field("word_number", 64'(w.wnum), 64'(word_number));
				check_field("value_word", w.word, value_word);
				check_field("last", 64'(w.last), 64'(last));
				check_field("heartbeat_now", 64'(w.hb), 64'(heartbeat_now));
				check_field("sync_now", 64'(w.sync), 64'(sync_now));
			end
		end
	end

	initial begin
		int sent;
		int idle_mix [4][2];
		idle_mix = '{'{0, 0}, '{47, 0}, '{0, 47}, '{18, 18}};

		// short entry straight after reset, then sync extremes
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'hABC, 12'h123), 4'd8,
			64'hDDCCBBAA_04561234, 1'b1, '{KIND_DATA, 12'hABC, 16'h1234, 8'h56, 8'd4, 5'd0,
			64'h00000000_DDCCBBAA, 1'b1, HEARTBEAT_RESET, SYNC_RESET}});
		dir_rows.push_back('{mk_id(1'b1, SYNC_CODE, 12'hFFF, 12'hFFF), 4'd8,
			64'hFFFFFFFF_01FFFFFF, 1'b1, '{KIND_TRIGGER, 12'hFFF, 16'hFFFF, 8'hFF, 8'd0,
			5'd0, 64'd0, 1'b1, HEARTBEAT_RESET, SYNC_RESET}});
		dir_rows.push_back('{mk_id(1'b0, SYNC_CODE, 12'h001, 12'h000), 4'd4,
			64'h00000000_02000000, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SYNC_CODE, 12'h000, 12'h000), 4'd0,
			64'h00000000_01000000, 1'b1, '{KIND_TRIGGER, 12'h000, 16'h0000, 8'h00, 8'd0,
			5'd0, 64'd0, 1'b1, HEARTBEAT_RESET, SYNC_RESET}});
		// header too short, unknown commands
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h5A5, 12'hA5A), 4'd3,
			64'hFFFFFFFF_04000000, 1'b0, '0});
		dir_rows.push_back('{29'h1FFFFFFF, 4'd15, 64'hFFFFFFFF_FFFFFFFF, 1'b0, '0});
		dir_rows.push_back('{29'h0, 4'd0, 64'h0, 1'b0, '0});
		// interval updates at index 0
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h010, 12'h000), 4'd8,
			64'hEEEE1234_02000000, 1'b1, '{KIND_DATA, 12'h010, 16'h0000, 8'h00, 8'd2, 5'd0,
			64'h00000000_00001234, 1'b1, 16'h1234, SYNC_RESET}});
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h020, 12'h000), 4'd8,
			64'hFFFFFFFF_04010000, 1'b1, '{KIND_DATA, 12'h020, 16'h0000, 8'h01, 8'd4, 5'd0,
			64'h00000000_FFFFFFFF, 1'b1, 16'h1234, 16'hFFFF}});
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h030, 12'h000), 4'd4,
			64'h0, 1'b1, '{KIND_DATA, 12'h030, 16'h0000, 8'h00, 8'd0, 5'd0,
			64'd0, 1'b1, 16'hFFFF, 16'hFFFF}});
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h040, 12'h000), 4'd8,
			64'h00000000_02010000, 1'b1, '{KIND_DATA, 12'h040, 16'h0000, 8'h01, 8'd2, 5'd0,
			64'd0, 1'b1, 16'hFFFF, 16'h0000}});
		// one-segment entry, then a three-word entry out of order and re-delivered
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h100, 12'h000), 4'd8,
			64'h04030201_05032000, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h101, 12'h000), 4'd2,
			64'hFFFFFFFF_FFFF0500, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h200, 12'h000), 4'd8,
			64'h88776655_127FBEEF, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h201, 12'h000), 4'd8,
			64'h17161514_13121101, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h202, 12'h000), 4'd8,
			64'h0E0D0C0B_0A090800, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h203, 12'h000), 4'd8,
			64'hA6A5A4A3_A2A1A000, 1'b0, '0});
		// segment numbers out of range, segment past the entry end, over-long segment
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h204, 12'h000), 4'd8,
			64'h00000000_00000040, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b1, SEGMENT_CODE, 12'hFFF, 12'hFFF), 4'd15,
			64'hFFFFFFFF_FFFFFFFF, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h205, 12'h000), 4'd0,
			64'h00000000_00000005, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h206, 12'h000), 4'd15,
			64'hC7C6C5C4_C3C2C101, 1'b0, '0});
		// segment carrying no bytes still completes the entry
		dir_rows.push_back('{mk_id(1'b0, REQUEST_CODE, 12'h300, 12'h000), 4'd8,
			64'h12345678_0BFFFFFF, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h301, 12'h000), 4'd1,
			64'hFFFFFFFF_FFFFFF00, 1'b0, '0});
		dir_rows.push_back('{mk_id(1'b0, SEGMENT_CODE, 12'h302, 12'h000), 4'd8,
			64'hFFFFFFFF_FFFFFF3F, 1'b0, '0});

		wait (arst_n);
		@(posedge clk);
		foreach (dir_rows[r])
			send_frame(dir_rows[r].id, dir_rows[r].flen, dir_rows[r].data,
				dir_rows[r].typed, dir_rows[r].want);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p][0];
			recv_stall_pct = idle_mix[p][1];
			sent = 0;
			// full-length entry first so store bytes 0..254 are written before random use
			if (p == 0)
				send_entry(255, 1'b1, sent);
			run_random(75 - sent);
			wait_drained();
		end

		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
src/cser_pkg.sv
src/cser_ram.sv
src/cser_merge.sv
src/can_segmented_entry_reassembler_core.sv
tb/sv/tb.sv
